[rtl/core/lpd_pkg.sv]
// Package: shared types and constants of the length-prefix deframer
package lpd_pkg;

   // Frame header size in bytes (1 to 4)
   localparam int unsigned HEADER_BYTES = 4;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes (word address, paddr[2])
   typedef enum logic [0:0] {
      REG_MAX_FRAME_BYTES = 1'b0
   } reg_index_type;

   // Reset value of the maximum frame length register
   localparam logic [31:0] MAX_FRAME_BYTES_RESET = 32'd1048576;

   // Deframer phase
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_BYTE      = 3'd0,
      ST_LAST      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_TRUNC     = 3'd4,
      ST_CLEAN     = 3'd5
   } status_type;

endpackage

[rtl/core/lpd_req_if.sv]
// Interface: input byte stream channel of the deframer
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

[rtl/core/lpd_rsp_if.sv]
// Interface: result channel of the deframer
interface lpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] payload_byte;

   modport source (output valid, output status, output payload_byte, input ready);
   modport sink (input valid, input status, input payload_byte, output ready);
endinterface

[rtl/core/length_prefix_deframer_unit.sv]
// Top level: length-prefix deframer with input register, step logic and result register
//
//   channel   direction  transaction
//   req_bus   in         one stream byte or an end-of-stream marker
//   rsp_bus   out        one status with an optional payload byte
//   csr_*     in/out     APB write/read of max_frame_bytes at byte address 0
//
// One transaction enters per cycle unless stalled; it sits in the input register, and its
// result (if any) is then loaded into the result register. Throughput is one byte per cycle
// while the result slot is free or draining, set by the combinational step over the 32-bit
// length compare and byte counter. Reset is synchronous and restores header phase and
// max_frame_bytes. A held result stalls the input register only while rsp ready is low.
module length_prefix_deframer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   lpd_req_if.sink                                req_bus,
   lpd_rsp_if.source                              rsp_bus,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lpd_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [lpd_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [lpd_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   // Configuration register
   logic [31:0] max_frame_ff;
   logic        csr_write;
   logic        csr_hit;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;

   // Deframer state
   lpd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  hcount_ff, hcount_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] remain_ff, remain_in;

   // Result register
   logic                 out_valid_ff;
   lpd_pkg::status_type  out_status_ff;
   logic [7:0]           out_byte_ff;

   // Step decode
   logic                 advance;
   logic                 res_valid;
   lpd_pkg::status_type  res_status;
   logic [7:0]           res_byte;
   logic [31:0]          header_len;
   logic [2:0]           hcount_inc;
   logic                 header_done;
   logic                 remain_last;
   logic [31:0]          remain_dec;
   logic                 end_clean;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == lpd_pkg::REG_MAX_FRAME_BYTES);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_hit;
   assign csr_prdata = csr_hit ? max_frame_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= lpd_pkg::MAX_FRAME_BYTES_RESET;
      end else if (csr_write) begin
         max_frame_ff <= csr_pwdata;
      end
   end

   // Advance the input register whenever the result slot is free or draining
   assign advance       = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
         in_end_ff  <= req_bus.stream_end;
      end
   end

   // Shared decode of the current byte against the state
   assign header_len  = acc_ff | ({24'd0, in_byte_ff} << {hcount_ff, 3'b000});
   assign hcount_inc  = {1'b0, hcount_ff} + 3'd1;
   assign header_done = (hcount_inc >= 3'(lpd_pkg::HEADER_BYTES));
   assign remain_last = (remain_ff[31:1] == 31'd0);
   assign remain_dec  = remain_ff - 32'd1;
   assign end_clean   = (phase_ff != lpd_pkg::PH_PAYLOAD) &&
                        (phase_ff != lpd_pkg::PH_DISCARD) && (hcount_ff == 2'd0);

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      acc_in    = acc_ff;
      remain_in = remain_ff;
      if (in_end_ff) begin
         phase_in  = lpd_pkg::PH_HEADER;
         hcount_in = 2'd0;
         acc_in    = 32'd0;
         remain_in = 32'd0;
      end else begin
         unique case (phase_ff)
            lpd_pkg::PH_PAYLOAD, lpd_pkg::PH_DISCARD: begin
               if (remain_last) begin
                  phase_in  = lpd_pkg::PH_HEADER;
                  hcount_in = 2'd0;
                  acc_in    = 32'd0;
                  remain_in = 32'd0;
               end else begin
                  remain_in = remain_dec;
               end
            end
            default: begin
               phase_in = lpd_pkg::PH_HEADER;
               if (header_done) begin
                  hcount_in = 2'd0;
                  acc_in    = 32'd0;
                  if (header_len > max_frame_ff) begin
                     phase_in  = lpd_pkg::PH_DISCARD;
                     remain_in = header_len;
                  end else if (header_len == 32'd0) begin
                     remain_in = 32'd0;
                  end else begin
                     phase_in  = lpd_pkg::PH_PAYLOAD;
                     remain_in = header_len;
                  end
               end else begin
                  hcount_in = hcount_inc[1:0];
                  acc_in    = header_len;
               end
            end
         endcase
      end
   end

   // Result of the current byte
   always_comb begin
      res_valid  = 1'b0;
      res_status = lpd_pkg::ST_BYTE;
      res_byte   = 8'd0;
      if (in_end_ff) begin
         res_valid  = 1'b1;
         res_status = end_clean ? lpd_pkg::ST_CLEAN : lpd_pkg::ST_TRUNC;
      end else begin
         unique case (phase_ff)
            lpd_pkg::PH_PAYLOAD: begin
               res_valid  = 1'b1;
               res_status = remain_last ? lpd_pkg::ST_LAST : lpd_pkg::ST_BYTE;
               res_byte   = in_byte_ff;
            end
            lpd_pkg::PH_DISCARD: begin
               res_valid  = remain_last;
               res_status = lpd_pkg::ST_TOO_LARGE;
            end
            default: begin
               res_valid  = header_done && (header_len <= max_frame_ff) &&
                            (header_len == 32'd0);
               res_status = lpd_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   // Update state on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lpd_pkg::PH_HEADER;
         hcount_ff <= 2'd0;
         acc_ff    <= 32'd0;
         remain_ff <= 32'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
      end
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_status_ff <= res_status;
         out_byte_ff   <= res_byte;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.payload_byte = out_byte_ff;

endmodule

[tb/tb_length_prefix_deframer_unit.sv]
// Testbench: length-prefix deframer checked against a cycle-free predictor with random traffic
module tb_length_prefix_deframer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int WHOLE_FRAME    = 1 << 30;
   localparam logic [lpd_pkg::CSR_ADDR_WIDTH-1:0] MAX_LEN_ADDR =
      lpd_pkg::CSR_ADDR_WIDTH'({lpd_pkg::REG_MAX_FRAME_BYTES, 2'b00});

   typedef struct packed {
      lpd_pkg::status_type status;
      logic [7:0]          payload_byte;
   } deframe_result_type;

   typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_type;

   logic clock;
   logic reset;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [lpd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [lpd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [lpd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   lpd_req_if req_bus ();
   lpd_rsp_if rsp_bus ();

   length_prefix_deframer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state, mirrors the block after each accepted transaction
   lpd_pkg::phase_type pred_phase;
   logic [1:0]  pred_hdr_count;
   logic [31:0] pred_length;
   logic [31:0] pred_remaining;
   logic [31:0] pred_max_len;

   deframe_result_type predicted_deframe_out[$];

   int  mismatch_count;
   int  items_sent;
   int  burst_left;
   bit  gaps_enabled;
   int  cycle_count;
   bit  holdoff_pending;
   int  holdoff_left;
   rx_mode_type rx_mode;
   int          rx_mode_left;
   logic [7:0]  rx_pattern;

   // Generate clock
   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // Return to the between-frames state
   function automatic void clear_deframe_state();
      pred_phase     = lpd_pkg::PH_HEADER;
      pred_hdr_count = '0;
      pred_length    = '0;
      pred_remaining = '0;
   endfunction

   // Advance the predictor by one transaction and report its result, if any
   function automatic void deframe_byte(input logic [7:0] data_byte, input logic stream_end,
                                        output bit produced, output deframe_result_type res);
      logic [31:0] full_len;
      produced         = 1'b0;
      res.status       = lpd_pkg::ST_BYTE;
      res.payload_byte = '0;
      if (stream_end) begin
         produced = 1'b1;
         if (pred_phase != lpd_pkg::PH_PAYLOAD && pred_phase != lpd_pkg::PH_DISCARD &&
             pred_hdr_count == 0)
            res.status = lpd_pkg::ST_CLEAN;
         else
            res.status = lpd_pkg::ST_TRUNC;
         clear_deframe_state();
      end else begin
         case (pred_phase)
            lpd_pkg::PH_PAYLOAD: begin
               if (pred_remaining != 0) pred_remaining--;
               produced         = 1'b1;
               res.payload_byte = data_byte;
               if (pred_remaining == 0) begin
                  res.status = lpd_pkg::ST_LAST;
                  clear_deframe_state();
               end else begin
                  res.status = lpd_pkg::ST_BYTE;
               end
            end
            lpd_pkg::PH_DISCARD: begin
               if (pred_remaining != 0) pred_remaining--;
               if (pred_remaining == 0) begin
                  produced   = 1'b1;
                  res.status = lpd_pkg::ST_TOO_LARGE;
                  clear_deframe_state();
               end
            end
            default: begin
               pred_phase  = lpd_pkg::PH_HEADER;
               pred_length = pred_length | (32'(data_byte) << (8 * pred_hdr_count));
               if (int'(pred_hdr_count) + 1 >= lpd_pkg::HEADER_BYTES) begin
                  full_len       = pred_length;
                  pred_hdr_count = '0;
                  pred_length    = '0;
                  if (full_len > pred_max_len) begin
                     pred_phase     = lpd_pkg::PH_DISCARD;
                     pred_remaining = full_len;
                  end else if (full_len == 0) begin
                     produced   = 1'b1;
                     res.status = lpd_pkg::ST_EMPTY;
                     clear_deframe_state();
                  end else begin
                     pred_phase     = lpd_pkg::PH_PAYLOAD;
                     pred_remaining = full_len;
                  end
               end else begin
                  pred_hdr_count = pred_hdr_count + 2'd1;
               end
            end
         endcase
      end
   endfunction

   // Offer one transaction, in bursts with random gaps, and predict its result on acceptance
   task automatic send_byte(input logic [7:0] data_byte, input logic stream_end);
      int gap;
      bit produced;
      deframe_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (!gaps_enabled) gap = 0;
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= data_byte;
      req_bus.stream_end <= stream_end;
      do @(posedge clock); while (!req_bus.ready);
      deframe_byte(data_byte, stream_end, produced, res);
      if (produced) predicted_deframe_out.push_back(res);
      items_sent++;
   endtask

   // Send a length header and random body bytes, stopping after limit transactions
   task automatic send_frame(input logic [31:0] len, input int limit);
      for (int k = 0; longint'(k) < longint'(len) + lpd_pkg::HEADER_BYTES && k < limit;
           k++) begin
         if (k < lpd_pkg::HEADER_BYTES)
            send_byte(len[8*k +: 8], 1'b0);
         else
            send_byte(8'($urandom), 1'b0);
      end
   endtask

   // Hold the input idle until every predicted result has come out and the pipe is empty
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (predicted_deframe_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_check(input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MAX_LEN_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== want)
         log_mismatch($sformatf("max_frame_bytes read: expected %h, got %h", want, got));
   endtask

   // Write the length limit once the block is idle, then read it back
   task automatic set_frame_limit(input logic [31:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_LEN_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      pred_max_len = value;
      @(posedge clock);
      csr_check(value);
   endtask

   // Lengths stay short so that passed and discarded bodies complete quickly
   function automatic logic [31:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return (pred_max_len <= 32'd32) ? pred_max_len : 32'd1;
         2: return (pred_max_len < 32'd32) ? pred_max_len + 32'd1 : 32'd2;
         3: return 32'd1;
         default: return 32'($urandom_range(1, 32));
      endcase
   endfunction

   task automatic test_reset_value();
      csr_check(lpd_pkg::MAX_FRAME_BYTES_RESET);
   endtask

   task automatic test_frame_basics();
      set_frame_limit(lpd_pkg::MAX_FRAME_BYTES_RESET);
      // Empty frame, then a two-byte frame with extreme payload values, then a clean close
      send_frame(32'd0, WHOLE_FRAME);
      send_frame(32'd2, lpd_pkg::HEADER_BYTES);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_length_limit();
      set_frame_limit(32'd1);
      // Length equal to the limit passes, one above it is discarded
      send_frame(32'd1, WHOLE_FRAME);
      send_frame(32'd2, WHOLE_FRAME);
      // Close the stream inside a header
      send_frame(32'd2, 2);
      send_byte(8'h5A, 1'b1);
   endtask

   task automatic test_truncation();
      set_frame_limit(32'hFFFF_FFFF);
      // Largest length accepted, stream closes inside the payload
      send_frame(32'hFFFF_FFFF, lpd_pkg::HEADER_BYTES + 1);
      send_byte(8'h00, 1'b1);
      set_frame_limit(32'd0);
      // Stream closes inside a discard
      send_frame(32'd3, lpd_pkg::HEADER_BYTES + 1);
      send_byte(8'hC3, 1'b1);
   endtask

   task automatic test_random_traffic(input logic [31:0] limit_value, input int n_items);
      int stop;
      int cut;
      int pick;
      logic [31:0] len;
      set_frame_limit(limit_value);
      stop = items_sent + n_items;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            len = pick_length();
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(0, lpd_pkg::HEADER_BYTES + int'(len) - 1);
               send_frame(len, cut);
               send_byte(8'($urandom), 1'b1);
            end else begin
               send_frame(len, WHOLE_FRAME);
            end
         end else if (pick < 17) begin
            send_byte(8'($urandom), 1'b1);
         end else begin
            // Broken sequence: a random header, cut after 1 to HEADER_BYTES + 3 bytes, then close
            send_frame($urandom, $urandom_range(1, lpd_pkg::HEADER_BYTES + 3));
            send_byte(8'($urandom), 1'b1);
         end
      end
   endtask

   task automatic test_back_pressure();
      int stop;
      set_frame_limit(32'd64);
      gaps_enabled = 1'b0;
      holdoff_pending <= 1'b1;
      stop = items_sent + 120;
      while (items_sent < stop) send_frame(32'($urandom_range(1, 16)), WHOLE_FRAME);
      gaps_enabled = 1'b1;
      wait_idle();
   endtask

   // Drive result ready: long hold-off on request, otherwise random stall modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_bus.ready <= 1'b0;
         holdoff_left--;
      end else if (holdoff_pending) begin
         holdoff_pending <= 1'b0;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(8, 64);
            rx_pattern   = 8'($urandom) | 8'h01;
         end
         rx_mode_left--;
         case (rx_mode)
            RX_OPEN: rsp_bus.ready <= 1'b1;
            RX_COIN: rsp_bus.ready <= 1'($urandom);
            RX_PATTERN: begin
               rsp_bus.ready <= rx_pattern[0];
               rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            end
            default: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      deframe_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_deframe_out.size() == 0) begin
            log_mismatch($sformatf("unexpected result: status %0d byte %h",
                                   rsp_bus.status, rsp_bus.payload_byte));
         end else begin
            want = predicted_deframe_out.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.payload_byte !== want.payload_byte)
               log_mismatch($sformatf("result: expected status %0d byte %h, got status %0d byte %h",
                                      want.status, want.payload_byte,
                                      rsp_bus.status, rsp_bus.payload_byte));
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.stream_end = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      mismatch_count     = 0;
      items_sent         = 0;
      burst_left         = 0;
      gaps_enabled       = 1'b1;
      cycle_count        = 0;
      holdoff_pending    = 1'b0;
      holdoff_left       = 0;
      rx_mode            = RX_OPEN;
      rx_mode_left       = 0;
      rx_pattern         = 8'hFF;
      pred_max_len       = lpd_pkg::MAX_FRAME_BYTES_RESET;
      clear_deframe_state();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_frame_basics();
      test_length_limit();
      test_truncation();
      test_random_traffic(32'd16, 300);
      test_random_traffic(32'd0, 120);
      test_random_traffic(32'hFFFF_FFFF, 200);
      test_random_traffic(lpd_pkg::MAX_FRAME_BYTES_RESET, 150);
      test_back_pressure();
      test_random_traffic(32'd5, 200);
      wait_idle();

      if (predicted_deframe_out.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", predicted_deframe_out.size()));
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
